>>> src/discrete_distribution_sampler_unit_defines.svh
// Assertion macros for the discrete distribution sampler.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef DISCRETE_DISTRIBUTION_SAMPLER_UNIT_DEFINES_SVH
`define DISCRETE_DISTRIBUTION_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dds_pkg.sv
// Shared types and codes for the discrete distribution sampler.
// No dependencies.
`timescale 1ns / 1ps

package dds_pkg;

  // Width of the bin index on the result port.
  localparam int unsigned BIN_W = 10;

  // Word kinds on the input port.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  // Top-level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SEARCH
  } state_e;

  // Scaling multiplier sequencer.
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_LO,
    SC_HI,
    SC_SUM
  } scale_state_e;

endpackage

>>> src/dds_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dds_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/dds_scale.sv
// Scales a random word by the table total: target = (random * total) >> RANDOM_BITS.
// One 32-bit multiplier used twice over the halves of the total. Uses dds_pkg.
`timescale 1ns / 1ps

module dds_scale #(
  parameter int unsigned RANDOM_BITS = 32,
  parameter int unsigned SUM_W       = 34
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RANDOM_BITS-1:0] random_i,
  input  logic [SUM_W-1:0]       total_i,
  output logic                   done_o,
  output logic [SUM_W-1:0]       target_o
);

  localparam int unsigned HalfW = 32;
  localparam int unsigned TotW  = 2 * HalfW;
  localparam int unsigned ProdW = RANDOM_BITS + HalfW;
  localparam int unsigned ShW   = ProdW + HalfW;

  dds_pkg::scale_state_e state_q, state_d;

  logic [RANDOM_BITS-1:0] rand_q;
  logic [TotW-1:0]        tot_q;
  logic [ProdW-1:0]       prod_q;
  logic [SUM_W-1:0]       lo_part_q;
  logic [SUM_W-1:0]       target_q;
  logic                   done_q;
  logic [HalfW-1:0]       mul_op;
  logic [ProdW-1:0]       mul_res;

  // Low half first, high half second.
  assign mul_op  = (state_q == dds_pkg::SC_LO) ? tot_q[HalfW-1:0] : tot_q[TotW-1:HalfW];
  assign mul_res = ProdW'(rand_q) * ProdW'(mul_op);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dds_pkg::SC_IDLE: if (start_i) state_d = dds_pkg::SC_LO;
      dds_pkg::SC_LO:   state_d = dds_pkg::SC_HI;
      dds_pkg::SC_HI:   state_d = dds_pkg::SC_SUM;
      dds_pkg::SC_SUM:  state_d = dds_pkg::SC_IDLE;
      default:          state_d = dds_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dds_pkg::SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == dds_pkg::SC_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dds_pkg::SC_IDLE && start_i) begin
      rand_q <= random_i;
      tot_q  <= TotW'(total_i);
    end
    if (state_q == dds_pkg::SC_LO || state_q == dds_pkg::SC_HI) begin
      prod_q <= mul_res;
    end
    if (state_q == dds_pkg::SC_HI) begin
      lo_part_q <= SUM_W'(prod_q >> RANDOM_BITS);
    end
    if (state_q == dds_pkg::SC_SUM) begin
      // High partial product carries weight 2^32 before the shift.
      target_q <= lo_part_q + SUM_W'(ShW'(prod_q) << (HalfW - RANDOM_BITS));
    end
  end

  assign done_o   = done_q;
  assign target_o = target_q;

endmodule

>>> src/discrete_distribution_sampler_unit.sv
// Top level of the discrete distribution sampler (tower sampling, binary search).
// Uses dds_pkg, dds_ram, dds_scale and the assertion macro header.
`timescale 1ns / 1ps
`include "discrete_distribution_sampler_unit_defines.svh"

// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ------------------------------------
// command   in         start_i & !busy_o       kind_i count_i last_bin_i random_word_i
// result    out        valid_o (1-cycle pulse) bin_index_o status_o
//
// A load word finishes in the cycle it is accepted: the new cumulative sum is
// written to the tower RAM at that edge, busy_o stays low, and no result word.
// A sample on an empty or zero-total table returns in the next cycle, no busy.
// Otherwise a sample holds busy_o through scaling (two passes through one
// 32x32 multiplier and an add) and the issue of the first RAM read, then
// one RAM read per search step, ceil(log2(bins+1)) steps.
// Reset clears table bookkeeping and sequencers; the RAM needs no clearing pass since
// only entries written by the current table are ever read. Results cannot stall.

module discrete_distribution_sampler_unit #(
  parameter int unsigned MAX_BINS    = 1024,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned RANDOM_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   kind_i,
  input  logic [COUNT_BITS-1:0]  count_i,
  input  logic                   last_bin_i,
  input  logic [RANDOM_BITS-1:0] random_word_i,
  output logic                   valid_o,
  output logic [9:0]             bin_index_o,
  output logic [1:0]             status_o
);

  localparam int unsigned IdxW = $clog2(MAX_BINS);
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);
  localparam int unsigned SumW = COUNT_BITS + IdxW;
  localparam int unsigned BinW = dds_pkg::BIN_W;

  // Table bookkeeping.
  logic [CntW-1:0] n_q, n_d;
  logic [SumW-1:0] total_q, total_d;
  logic            closed_q, closed_d;
  logic            dropped_q, dropped_d;

  // Search state.
  dds_pkg::state_e state_q, state_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  // Result register.
  logic             valid_q, valid_d;
  logic [BinW-1:0]  bin_q, bin_d;
  dds_pkg::status_e status_q, status_d;

  logic            accept;
  logic            is_load;
  logic            table_empty;
  logic [CntW-1:0] base_n;
  logic [SumW-1:0] base_tot;
  logic [SumW-1:0] new_sum;
  logic            ram_we;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [SumW-1:0] rd_data;
  logic            scale_start;
  logic            scale_done;
  logic [SumW-1:0] target;
  logic            step_le;
  logic [CntW-1:0] step_lo, step_hi, step_mid;

  assign accept      = start_i && !busy_o;
  assign is_load     = (kind_i == dds_pkg::KIND_LOAD);
  assign table_empty = (n_q == '0) || (total_q == '0);
  assign busy_o      = (state_q != dds_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Load path: a load after a closed table starts a fresh one at bin 0.
  // ---------------------------------------------------------------------------
  assign base_n   = closed_q ? '0 : n_q;
  assign base_tot = closed_q ? '0 : total_q;
  assign new_sum  = base_tot + SumW'(count_i);

  always_comb begin
    n_d       = n_q;
    total_d   = total_q;
    closed_d  = closed_q;
    dropped_d = dropped_q;
    ram_we    = 1'b0;
    if (accept && is_load) begin
      closed_d = last_bin_i;
      if (base_n < CntW'(MAX_BINS)) begin
        ram_we    = 1'b1;
        n_d       = base_n + CntW'(1);
        total_d   = new_sum;
        dropped_d = closed_q ? 1'b0 : dropped_q;
      end else begin
        // Table full: count is ignored, flag sticks until the next table.
        n_d       = base_n;
        total_d   = base_tot;
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      total_q   <= '0;
      closed_q  <= 1'b1;
      dropped_q <= 1'b0;
    end else begin
      n_q       <= n_d;
      total_q   <= total_d;
      closed_q  <= closed_d;
      dropped_q <= dropped_d;
    end
  end

  dds_ram #(
    .DEPTH (MAX_BINS),
    .WIDTH (SumW)
  ) u_tower (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (base_n[IdxW-1:0]),
    .wr_data_i (new_sum),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dds_scale #(
    .RANDOM_BITS (RANDOM_BITS),
    .SUM_W       (SumW)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scale_start),
    .random_i (random_word_i),
    .total_i  (total_q),
    .done_o   (scale_done),
    .target_o (target)
  );

  // ---------------------------------------------------------------------------
  // Search step: rd_data is the sum at mid_q; narrow [lo, hi) and issue the
  // next read in the same cycle so each step costs one RAM access.
  // ---------------------------------------------------------------------------
  assign step_le  = (rd_data <= target);
  assign step_lo  = step_le ? (mid_q + CntW'(1)) : lo_q;
  assign step_hi  = step_le ? hi_q : mid_q;
  assign step_mid = step_lo + ((step_hi - step_lo) >> 1);

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    valid_d     = 1'b0;
    bin_d       = bin_q;
    status_d    = status_q;
    rd_en       = 1'b0;
    rd_addr     = mid_q[IdxW-1:0];
    scale_start = 1'b0;
    case (state_q)
      dds_pkg::ST_IDLE: begin
        if (accept && !is_load) begin
          if (table_empty) begin
            valid_d  = 1'b1;
            bin_d    = '0;
            status_d = dds_pkg::STATUS_EMPTY;
          end else begin
            scale_start = 1'b1;
            state_d     = dds_pkg::ST_SCALE;
          end
        end
      end
      dds_pkg::ST_SCALE: begin
        if (scale_done) begin
          lo_d    = '0;
          hi_d    = n_q;
          mid_d   = n_q >> 1;
          rd_en   = 1'b1;
          rd_addr = mid_d[IdxW-1:0];
          state_d = dds_pkg::ST_SEARCH;
        end
      end
      dds_pkg::ST_SEARCH: begin
        lo_d = step_lo;
        hi_d = step_hi;
        if (step_lo < step_hi) begin
          mid_d   = step_mid;
          rd_en   = 1'b1;
          rd_addr = step_mid[IdxW-1:0];
        end else begin
          valid_d  = 1'b1;
          bin_d    = BinW'(step_lo);
          status_d = dropped_q ? dds_pkg::STATUS_DROPPED : dds_pkg::STATUS_OK;
          state_d  = dds_pkg::ST_IDLE;
        end
      end
      default: state_d = dds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dds_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    bin_q    <= bin_d;
    status_q <= status_d;
  end

  assign valid_o     = valid_q;
  assign bin_index_o = bin_q;
  assign status_o    = status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DDS_ASSERT_IMP(a_no_write_in_search, ram_we, state_q == dds_pkg::ST_IDLE, "tower written while busy")
  `DDS_ASSERT_IMP(a_search_bounds, state_q == dds_pkg::ST_SEARCH, (lo_q < hi_q) && (hi_q <= n_q) && (mid_q >= lo_q) && (mid_q < hi_q), "search window out of range")
  `DDS_ASSERT_NXT(a_scale_done_in_time, scale_start, busy_o && !scale_done, "scaler done too early")
  `DDS_ASSERT_IMP(a_result_origin, valid_o, $past(state_q == dds_pkg::ST_SEARCH) || $past(accept && !is_load), "result without sample")
  `DDS_ASSERT_IMP(a_empty_status, valid_o && (status_o == dds_pkg::STATUS_EMPTY), bin_index_o == '0, "empty table result with nonzero index")

endmodule

>>> test/discrete_distribution_sampler_unit_tb.sv
// Self-checking testbench for discrete_distribution_sampler_unit: loads bin-count tables,
// draws samples and checks each result word against an in-bench tower predictor.
// Depends on dds_pkg and the sampler top level; needs no files or arguments.
`timescale 1ns / 1ps

module discrete_distribution_sampler_unit_tb;

  localparam int unsigned MAX_BINS    = 1024;
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned RANDOM_BITS = 32;
  localparam int unsigned RAND_WORDS  = 100;   // rough size of the random part
  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no word moving either way
  localparam int unsigned DRAIN_WAIT  = 40;    // wait once every word is sent and every draw is back

  // One command word plus how the sender treats it.
  typedef struct {
    bit                   kind;
    bit [COUNT_BITS-1:0]  count;
    bit                   last;
    bit [RANDOM_BITS-1:0] rnd;
    int unsigned          gap;    // idle cycles before this word is offered
    bit                   drain;  // hold this word until every result is back
  } cmd_t;

  // One predicted draw.
  typedef struct packed {
    logic [dds_pkg::BIN_W-1:0] bin;
    dds_pkg::status_e          status;
  } draw_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      kind_i = dds_pkg::KIND_LOAD;
  logic [COUNT_BITS-1:0]     count_i = '0;
  logic                      last_bin_i = 1'b0;
  logic [RANDOM_BITS-1:0]    random_word_i = '0;
  logic                      busy_o;
  logic                      valid_o;
  logic [dds_pkg::BIN_W-1:0] bin_index_o;
  logic [1:0]                status_o;

  discrete_distribution_sampler_unit #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS),
    .RANDOM_BITS(RANDOM_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .count_i      (count_i),
    .last_bin_i   (last_bin_i),
    .random_word_i(random_word_i),
    .valid_o      (valid_o),
    .bin_index_o  (bin_index_o),
    .status_o     (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Stimulus store and result bookkeeping.
  cmd_t        cmd_q[$];
  draw_t       drawn_q[$];
  cmd_t        cur_cmd;
  int unsigned total_words = 0;
  int unsigned sent_cnt = 0;     // words accepted by the block
  int unsigned pred_cnt = 0;     // draws predicted (driver owned)
  int unsigned rcvd_cnt = 0;     // draws seen on the result port
  int unsigned fail_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;

  // Tower predictor state: cumulative sums of the current table.
  logic [33:0] tower_sum[MAX_BINS];
  int unsigned tower_bins = 0;
  logic [33:0] tower_total = '0;
  bit          tower_closed = 1'b1;
  bit          tower_dropped = 1'b0;

  // Apply one accepted word to the tower; a sample queues its expected draw.
  task automatic tower_step(input cmd_t c);
    draw_t       draw;
    logic [65:0] prod;
    logic [33:0] target;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (c.kind == dds_pkg::KIND_LOAD) begin
      // a load after a closed table opens a fresh one
      if (tower_closed) begin
        tower_bins    = 0;
        tower_total   = '0;
        tower_dropped = 1'b0;
        tower_closed  = 1'b0;
      end
      if (tower_bins < MAX_BINS) begin
        tower_total           = tower_total + 34'(c.count);
        tower_sum[tower_bins] = tower_total;
        tower_bins++;
      end else begin
        tower_dropped = 1'b1;  // table full, count is lost
      end
      if (c.last) tower_closed = 1'b1;
    end else begin
      if (tower_bins == 0 || tower_total == '0) begin
        draw.bin    = '0;
        draw.status = dds_pkg::STATUS_EMPTY;
      end else begin
        prod   = {34'd0, c.rnd} * {32'd0, tower_total};
        target = prod[65:32];
        // count of cumulative sums <= target
        lo = 0;
        hi = tower_bins;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (tower_sum[mid] <= target) lo = mid + 1;
          else hi = mid;
        end
        draw.bin    = lo[dds_pkg::BIN_W-1:0];
        draw.status = tower_dropped ? dds_pkg::STATUS_DROPPED : dds_pkg::STATUS_OK;
      end
      drawn_q.push_back(draw);
      pred_cnt++;
    end
  endtask

  // Driver: offers queued words, holds start_i until the block takes them.
  always @(posedge clk_i) begin
    bit          take;
    int unsigned wait_n;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      take = start_i && !busy_o;
      if (take) begin
        tower_step(cur_cmd);
        sent_cnt <= sent_cnt + 1;
      end
      if (!(start_i && !take)) begin
        wait_n = take ? ((cmd_q.size() != 0) ? cmd_q[0].gap : 0) : gap_left;
        if (wait_n != 0) begin
          gap_left <= wait_n - 1;
          start_i  <= 1'b0;
        end else if (cmd_q.size() != 0 && (!cmd_q[0].drain || pred_cnt == rcvd_cnt)) begin
          cur_cmd = cmd_q.pop_front();
          start_i       <= 1'b1;
          kind_i        <= cur_cmd.kind;
          count_i       <= cur_cmd.count;
          last_bin_i    <= cur_cmd.last;
          random_word_i <= cur_cmd.rnd;
        end else begin
          start_i <= 1'b0;  // out of words, or draining before the next one
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest predicted draw.
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && valid_o) begin
      rcvd_cnt <= rcvd_cnt + 1;
      if (drawn_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got bin_index %0d status %0d",
                 $time, bin_index_o, status_o);
        fail_cnt++;
      end else begin
        want = drawn_q.pop_front();
        if (bin_index_o !== want.bin) begin
          $display("%0t: bin_index expected %0d, got %0d", $time, want.bin, bin_index_o);
          fail_cnt++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too long with nothing moving means the block hung.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("discrete_distribution_sampler_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_load(input bit [COUNT_BITS-1:0] cnt, input bit last,
                           input int unsigned gap, input bit drain);
    cmd_t c;
    c.kind  = dds_pkg::KIND_LOAD;
    c.count = cnt;
    c.last  = last;
    c.rnd   = RANDOM_BITS'($urandom());  // ignored on loads
    c.gap   = gap;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  task automatic push_sample(input bit [RANDOM_BITS-1:0] rnd,
                             input int unsigned gap, input bit drain);
    cmd_t c;
    c.kind  = dds_pkg::KIND_SAMPLE;
    c.count = COUNT_BITS'($urandom());  // ignored on samples
    c.last  = 1'($urandom_range(0, 1));
    c.rnd   = rnd;
    c.gap   = gap;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // Counts lean on the corners: zero, full scale and small values.
  function automatic bit [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return COUNT_BITS'($urandom_range(1, 15));
      default: return COUNT_BITS'($urandom());
    endcase
  endfunction

  function automatic bit [RANDOM_BITS-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RANDOM_BITS'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  initial begin
    int unsigned nbins;
    int unsigned nsamp;
    bit          burst;
    bit          zero_tab;
    bit          closes;

    // Directed words.
    push_sample('1, pick_gap(0), 0);                   // sample right after reset
    push_load('0, 1, pick_gap(0), 0);                  // one-bin table, total zero
    push_sample('0, pick_gap(0), 0);
    push_load('0, 0, pick_gap(0), 0);                  // leading empty bins
    push_load('0, 0, pick_gap(0), 0);
    push_load(24'd4, 1, pick_gap(0), 0);
    push_sample('0, pick_gap(0), 0);                   // target zero skips empty bins
    push_sample('1, pick_gap(0), 0);
    push_load('1, 0, pick_gap(0), 0);                  // new table, left open
    push_sample(32'h8000_0000, pick_gap(0), 0);        // sample on an open table
    push_load('0, 0, pick_gap(0), 0);
    push_load(24'd1, 0, pick_gap(0), 0);
    push_load('1, 1, pick_gap(0), 0);
    push_sample('0, pick_gap(0), 0);
    push_sample('1, pick_gap(0), 0);
    push_sample(32'h8000_0000, pick_gap(0), 0);
    push_load(24'd1, 1, pick_gap(0), 0);
    push_sample(32'h5a5a_5a5a, pick_gap(0), 0);
    push_sample(32'ha5a5_a5a5, pick_gap(0), 0);

    // Full table: every slot used, then overflow words that get dropped.
    for (int unsigned b = 0; b < MAX_BINS; b++) begin
      push_load(pick_count(), 0, pick_gap($urandom_range(0, 15) != 0), b == 0);
    end
    for (int unsigned s = 0; s < 3; s++) push_sample(pick_word(), pick_gap(0), 0);
    push_load(pick_count(), 0, pick_gap(0), 0);        // dropped, table stays open
    push_sample(pick_word(), pick_gap(0), 0);
    push_load(pick_count(), 1, pick_gap(0), 0);        // dropped, still closes the table
    for (int unsigned s = 0; s < 3; s++) push_sample(pick_word(), pick_gap(0), 0);

    // Random tables with random draws; a few are never closed and run on.
    total_words = cmd_q.size();
    while (cmd_q.size() < total_words + RAND_WORDS) begin
      burst    = ($urandom_range(0, 3) == 0);
      nbins    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      zero_tab = ($urandom_range(0, 9) == 0);
      closes   = ($urandom_range(0, 6) != 0);
      for (int unsigned b = 0; b < nbins; b++) begin
        push_load(zero_tab ? '0 : pick_count(), closes && b == nbins - 1,
                  pick_gap(burst), $urandom_range(0, 49) == 0);
        if ($urandom_range(0, 19) == 0) push_sample(pick_word(), pick_gap(burst), 0);
      end
      nsamp = $urandom_range(1, 6);
      for (int unsigned s = 0; s < nsamp; s++) begin
        push_sample(pick_word(), pick_gap(burst), $urandom_range(0, 49) == 0);
      end
    end
    total_words = cmd_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampling on the falling edge keeps clear of the clocked blocks.
    @(negedge clk_i);
    while (sent_cnt != total_words || drawn_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("discrete_distribution_sampler_unit: match");
    end else begin
      $display("discrete_distribution_sampler_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/dds_pkg.sv
src/dds_ram.sv
src/dds_scale.sv
src/discrete_distribution_sampler_unit.sv
test/discrete_distribution_sampler_unit_tb.sv
